[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("telegram framer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("telegram framer check failed");

`endif

[rtl/tfc_pkg.sv]
// Package: characters, status codes, result type and CRC/hex helpers of the telegram framer.
`default_nettype none

package tfc_pkg;

	localparam logic [7:0] CHR_SLASH = 8'h2F;
	localparam logic [7:0] CHR_BANG  = 8'h21;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;

	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] MAX_LEN_RESET = 16'd2048;

	localparam int unsigned WIN_LEN  = 9;
	localparam int unsigned FOOT_LEN = 7;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CRC_BAD  = 2'd1,
		ST_NOT_HEX  = 2'd2,
		ST_OVERFLOW = 2'd3
	} frame_status_t;

	typedef struct packed {
		logic          has;
		logic [7:0]    ob;
		logic          bv;
		logic          fe;
		frame_status_t st;
		logic [15:0]   flen;
	} frame_res_t;

	// Reflected CRC-16 update by one byte, LSB first.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// {ok, value} for one ASCII hex digit, either case.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/tfc_frame_core.sv]
// Frame state, footer detection, CRC check and per-byte result of the telegram framer.
`default_nettype none

module tfc_frame_core
	import tfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  in_byte,
	input  wire logic [15:0] max_length,
	output frame_res_t       res
);

	logic        in_frame_q;
	logic [15:0] count_q;
	logic [15:0] crc_q;
	logic [7:0]  hist_q [WIN_LEN];

	logic        ovf;
	logic        open;
	logic        start;
	logic        take;
	logic        footer;
	logic [15:0] cnt_n;
	logic [15:0] crc_n;
	logic [7:0]  hist_n [WIN_LEN];
	logic [4:0]  d3, d2, d1, d0;
	logic [15:0] given;
	logic        hex_ok;

	always_comb begin
		ovf   = in_frame_q && (count_q >= max_length);
		open  = in_frame_q && !ovf;
		start = !open && (in_byte == CHR_SLASH);
		take  = open || start;

		hist_n[0] = in_byte;
		for (int i = 1; i < WIN_LEN; i++) begin
			hist_n[i] = hist_q[i-1];
		end

		// A new frame restarts count and CRC; older history is never read.
		cnt_n = start ? 16'd1 : count_q + 16'd1;
		crc_n = start ? 16'd0 : crc_q;
		if (cnt_n >= 16'(FOOT_LEN)) begin
			crc_n = crc_fold(crc_n, hist_n[6]);
		end

		footer = take && (cnt_n >= 16'(WIN_LEN)) &&
			(hist_n[0] == CHR_LF) && (hist_n[1] == CHR_CR) &&
			(hist_n[6] == CHR_BANG) && (hist_n[7] == CHR_LF) && (hist_n[8] == CHR_CR);

		d3 = hex_digit(hist_n[5]);
		d2 = hex_digit(hist_n[4]);
		d1 = hex_digit(hist_n[3]);
		d0 = hex_digit(hist_n[2]);
		hex_ok = d3[4] && d2[4] && d1[4] && d0[4];
		given  = {d3[3:0], d2[3:0], d1[3:0], d0[3:0]};

		res.bv   = take && (cnt_n >= 16'(FOOT_LEN + 1));
		res.ob   = res.bv ? hist_n[7] : 8'h00;
		res.fe   = ovf || footer;
		res.st   = ST_GOOD;
		res.flen = 16'd0;
		if (footer) begin
			res.flen = cnt_n - 16'(FOOT_LEN);
			if (!hex_ok) begin
				res.st = ST_NOT_HEX;
			end else if (given != crc_n) begin
				res.st = ST_CRC_BAD;
			end
		end else if (ovf) begin
			res.st   = ST_OVERFLOW;
			res.flen = (count_q >= 16'(FOOT_LEN + 1)) ? count_q - 16'(FOOT_LEN) : 16'd0;
		end
		res.has = res.bv || res.fe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= 16'd0;
			crc_q      <= 16'd0;
		end else if (step) begin
			in_frame_q <= take && !footer;
			if (take) begin
				count_q <= cnt_n;
				crc_q   <= crc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && take) begin
			hist_q <= hist_n;
		end
	end

endmodule

`default_nettype wire

[rtl/telegram_framer_crc16.sv]
// Top level of the telegram framer: input register, frame core and result register.
//
// Input channel in_valid/in_ready carries one received byte per item; the output
// channel out_valid/out_ready carries at most one result per input byte: a body
// byte (byte_valid), a frame end (frame_end with frame_status and frame_length),
// or both. Bytes outside a frame yield no result; footer bytes are never forwarded.
// Path: a result is offered from the result register once its byte has passed the
// input register and then the frame core's combinational step into that register.
// Throughput: one byte per cycle while out_ready is high; the CRC fold, footer
// match and length compare all fit in the one step between the two registers.
// Stall: when the result register is full and out_ready is low, the held byte
// waits in the input register and in_ready drops once that register is also full.
// Reset: no frame open, both registers empty, max_length back to 2048.
// cfg_we writes max_length directly; write it only while no byte is in flight.
`default_nettype none

module telegram_framer_crc16
	import tfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             frame_end,
	output logic [1:0]       frame_status,
	output logic [15:0]      frame_length
);

	logic [15:0] max_length_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	frame_res_t  res;
	frame_res_t  res_q;
	logic        out_valid_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	tfc_frame_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.in_byte    (byte_s1),
		.max_length (max_length_q),
		.res        (res)
	);

	// Load only items that produce a result; drain on out_ready otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.has) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.has) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = res_q.ob;
	assign byte_valid   = res_q.bv;
	assign frame_end    = res_q.fe;
	assign frame_status = res_q.st;
	assign frame_length = res_q.flen;

endmodule

`default_nettype wire

[rtl/tfc_checker.sv]
// Port-level checker of the telegram framer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module tfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_byte,
	input wire logic        byte_valid,
	input wire logic        frame_end,
	input wire logic [1:0]  frame_status,
	input wire logic [15:0] frame_length
);

	// An offered result always carries a body byte or a frame end.
	`TFC_ASSERT_IMP(a_has_content, clk, arst_n, out_valid, byte_valid || frame_end)

	// Status and length are zero unless the frame ends.
	`TFC_ASSERT_IMP(a_idle_fields, clk, arst_n, out_valid && !frame_end,
		frame_status == 2'd0 && frame_length == 16'd0)

	// No forwarded byte means a zero data field.
	`TFC_ASSERT_IMP(a_zero_byte, clk, arst_n, out_valid && !byte_valid, out_byte == 8'h00)

	// A stalled result holds.
	`TFC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(frame_end) && $stable(frame_length))

	// With nothing pending at the output, the input side is never blocked.
	`TFC_ASSERT_IMP(a_no_block, clk, arst_n, !out_valid && in_valid && !in_ready, 1'b0)

endmodule

bind telegram_framer_crc16 tfc_checker u_tfc_checker (.*);

`default_nettype wire
